FILE: rtl/core/inl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inl_pkg: shared types and constants of the identifier and number lexer
// Character and token formats, character classes, scanner states and the
// sizes of the internal queue and of the per-character token list.
// ---------------------------------------------------------------------------
package inl_pkg;

  // Width of the stream position counter; start_pos shows its low 16 bits.
  localparam int PosBits = 16;
  localparam int OutPosBits = 16;
  localparam int LenBits = 16;
  localparam logic [LenBits-1:0] LenMax = '1;

  // Entries of the queue between the classifier and the scanner.
  localparam int MidDepth = 2;

  // Token list size; a character yields at most three, terminator included.
  localparam int NumRes = 4;
  localparam int ResIdxBits = $clog2(NumRes);
  localparam int ResCntBits = $clog2(NumRes + 1);

  typedef enum logic [1:0] {
    KIND_IDENT  = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_ERROR  = 2'd2
  } inl_kind_e;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_EXP,
    CLS_DIGIT,
    CLS_DOT,
    CLS_UNDER,
    CLS_OTHER
  } inl_class_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_IDENT = 3'b010,
    MODE_NUM   = 3'b100
  } inl_mode_e;

  // Number table states S, A, B, C, D, E, F and the dead state T.
  localparam logic [2:0] NsS = 3'd0;
  localparam logic [2:0] NsA = 3'd1;
  localparam logic [2:0] NsB = 3'd2;
  localparam logic [2:0] NsC = 3'd3;
  localparam logic [2:0] NsD = 3'd4;
  localparam logic [2:0] NsE = 3'd5;
  localparam logic [2:0] NsF = 3'd6;
  localparam logic [2:0] NsT = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } inl_in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [OutPosBits-1:0] start_pos;
    logic [LenBits-1:0]    length;
    logic                  end_of_run;
  } inl_out_t;

  typedef struct packed {
    inl_class_e         cls;
    logic               last;
    logic [PosBits-1:0] pos;
  } inl_mid_t;

endpackage
`default_nettype wire

FILE: rtl/core/inl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inl_front: input side of the lexer
// Accepts characters, sorts each into a class and tags it with its stream
// position before it goes into the queue towards the scanner.
// ---------------------------------------------------------------------------
module inl_front import inl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire inl_in_t  item_i,
  input  wire logic     q_full_i,
  output logic          q_wr_o,
  output inl_mid_t      q_data_o
);

  logic [PosBits-1:0] pos_d, pos_q;
  inl_class_e         cls;

  always_comb begin
    if ((item_i.ch == 8'h65) || (item_i.ch == 8'h45)) begin
      cls = CLS_EXP;
    end else if (item_i.ch inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = CLS_LETTER;
    end else if (item_i.ch inside {[8'h30:8'h39]}) begin
      cls = CLS_DIGIT;
    end else if (item_i.ch == 8'h2E) begin
      cls = CLS_DOT;
    end else if (item_i.ch == 8'h5F) begin
      cls = CLS_UNDER;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign full     = q_full_i;
  assign q_wr_o   = push && !q_full_i;
  assign q_data_o = '{cls: cls, last: item_i.last, pos: pos_q};

  // A final character restarts the count for the next stream.
  always_comb begin
    pos_d = pos_q;
    if (q_wr_o) begin
      pos_d = item_i.last ? '0 : pos_q + PosBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/inl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inl_fifo: short queue between classifier and scanner
// Register-based queue of classified characters, so that either side can
// stall without holding up the other.
// ---------------------------------------------------------------------------
module inl_fifo import inl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire inl_mid_t wr_data_i,
  output logic          full_o,
  input  wire logic     rd_i,
  output logic          valid_o,
  output inl_mid_t      rd_data_o
);

  localparam int PtrBits = (MidDepth > 1) ? $clog2(MidDepth) : 1;
  localparam int CntBits = $clog2(MidDepth + 1);

  inl_mid_t           mem_q [MidDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_d, cnt_q;

  function automatic logic [PtrBits-1:0] ptr_next(input logic [PtrBits-1:0] p);
    logic [PtrBits-1:0] r;
    r = (p == PtrBits'(MidDepth - 1)) ? '0 : p + PtrBits'(1);
    return r;
  endfunction

  assign full_o    = (cnt_q == CntBits'(MidDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/inl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inl_back: scanner and token sequencer
// Runs the identifier and number scanner over the character at the head of
// the queue, lists the tokens it closes and hands them out one per cycle
// through the output register while pop keeps it free.
// ---------------------------------------------------------------------------
module inl_back import inl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     hd_valid_i,
  input  wire inl_mid_t hd_i,
  output logic          hd_pop_o,
  output logic          empty,
  input  wire logic     pop,
  output inl_out_t      token_o
);

  typedef enum logic [1:0] {
    RS_NONE,
    RS_AGAIN,
    RS_DROP_E
  } inl_rescan_e;

  typedef struct packed {
    inl_mode_e          mode;
    logic [2:0]         ns;
    logic [PosBits-1:0] start;
    logic [LenBits-1:0] len;
  } inl_scan_t;

  typedef struct packed {
    inl_scan_t   st;
    logic        emit;
    inl_out_t    tok;
    inl_rescan_e rescan;
  } inl_feed_t;

  // Number table; columns are digit, e/E and '.'.
  function automatic logic [2:0] ns_next(input logic [2:0] ns, input inl_class_e cls);
    logic [2:0] r;
    r = NsT;
    case (ns)
      NsS:     r = (cls == CLS_DIGIT) ? NsA : ((cls == CLS_DOT) ? NsC : NsT);
      NsA:     r = (cls == CLS_DIGIT) ? NsA : ((cls == CLS_DOT) ? NsB : NsE);
      NsB:     r = (cls == CLS_DIGIT) ? NsB : ((cls == CLS_DOT) ? NsT : NsE);
      NsC:     r = (cls == CLS_DIGIT) ? NsD : NsT;
      NsD:     r = (cls == CLS_DIGIT) ? NsD : ((cls == CLS_DOT) ? NsT : NsE);
      NsE:     r = (cls == CLS_DIGIT) ? NsF : NsT;
      NsF:     r = (cls == CLS_DIGIT) ? NsF : NsT;
      default: r = NsT;
    endcase
    return r;
  endfunction

  function automatic inl_out_t mk_tok(input inl_kind_e kind, input logic [PosBits-1:0] start,
                                      input logic [LenBits-1:0] len);
    inl_out_t t;
    t.kind       = kind;
    t.start_pos  = OutPosBits'(start);
    t.length     = len;
    t.end_of_run = 1'b0;
    return t;
  endfunction

  // One scanner step on one character, or on the terminator when term is set.
  function automatic inl_feed_t feed(input inl_scan_t st, input inl_class_e cls,
                                     input logic term, input logic [PosBits-1:0] pos);
    inl_feed_t          r;
    logic               letter, digit, numch;
    logic [2:0]         nx;
    logic [LenBits-1:0] grown;
    letter = (cls == CLS_LETTER) || (cls == CLS_EXP);
    digit  = (cls == CLS_DIGIT);
    numch  = digit || (cls == CLS_DOT) || (cls == CLS_EXP);
    nx     = ns_next(st.ns, cls);
    grown  = (st.len != LenMax) ? st.len + LenBits'(1) : st.len;
    r.st     = st;
    r.emit   = 1'b0;
    r.tok    = '0;
    r.rescan = RS_NONE;
    case (st.mode)
      MODE_IDLE: begin
        if (!term) begin
          if (letter) begin
            r.st.mode  = MODE_IDENT;
            r.st.start = pos;
            r.st.len   = LenBits'(1);
          end else if (digit || (cls == CLS_DOT)) begin
            r.st.mode  = MODE_NUM;
            r.st.start = pos;
            r.st.len   = LenBits'(1);
            r.st.ns    = digit ? NsA : NsC;
          end else if (cls != CLS_UNDER) begin
            r.emit = 1'b1;
            r.tok  = mk_tok(KIND_ERROR, pos, LenBits'(1));
          end
        end
      end
      MODE_IDENT: begin
        if (!term && (letter || digit)) begin
          r.st.len = grown;
        end else begin
          r.emit    = 1'b1;
          r.tok     = mk_tok(KIND_IDENT, st.start, st.len);
          r.st.mode = MODE_IDLE;
          r.st.ns   = NsS;
          r.rescan  = RS_AGAIN;
        end
      end
      MODE_NUM: begin
        if (!term && numch && (nx != NsT)) begin
          r.st.ns  = nx;
          r.st.len = grown;
        end else begin
          r.emit    = 1'b1;
          r.st.mode = MODE_IDLE;
          r.st.ns   = NsS;
          if (!(!term && numch) && (st.ns == NsE)) begin
            // The trailing e/E leaves the number; a saturated length stays.
            r.tok    = mk_tok(KIND_NUMBER, st.start,
                              (st.len != LenMax) ? st.len - LenBits'(1) : LenMax);
            r.rescan = RS_DROP_E;
          end else begin
            r.tok    = mk_tok(KIND_NUMBER, st.start, st.len);
            r.rescan = RS_AGAIN;
          end
        end
      end
      default: begin
        r.st.mode = MODE_IDLE;
        r.st.ns   = NsS;
      end
    endcase
    return r;
  endfunction

  inl_scan_t             st_q, st_next;
  inl_out_t              res [NumRes];
  logic [ResCntBits-1:0] n_res;
  logic [ResIdxBits-1:0] idx_d, idx_q;
  inl_out_t              out_d, out_q;
  logic                  out_valid_d, out_valid_q;
  logic                  load_ok, commit;

  always_comb begin
    inl_feed_t          f;
    inl_scan_t          s;
    logic [PosBits-1:0] pt;
    for (int i = 0; i < NumRes; i++) begin
      res[i] = '0;
    end
    n_res = '0;
    pt    = hd_i.pos + PosBits'(1);
    s     = st_q;

    f = feed(s, hd_i.cls, 1'b0, hd_i.pos);
    s = f.st;
    if (f.emit) begin
      res[n_res[ResIdxBits-1:0]] = f.tok;
      n_res = n_res + ResCntBits'(1);
    end
    if (f.rescan == RS_DROP_E) begin
      // The dropped e is rescanned at its own position, then the character.
      f = feed(s, CLS_EXP, 1'b0, hd_i.pos - PosBits'(1));
      s = f.st;
      f = feed(s, hd_i.cls, 1'b0, hd_i.pos);
      s = f.st;
      if (f.emit) begin
        res[n_res[ResIdxBits-1:0]] = f.tok;
        n_res = n_res + ResCntBits'(1);
      end
    end
    if (f.rescan == RS_AGAIN) begin
      f = feed(s, hd_i.cls, 1'b0, hd_i.pos);
      s = f.st;
      if (f.emit) begin
        res[n_res[ResIdxBits-1:0]] = f.tok;
        n_res = n_res + ResCntBits'(1);
      end
    end

    if (hd_i.last) begin
      f = feed(s, CLS_OTHER, 1'b1, pt);
      s = f.st;
      if (f.emit) begin
        res[n_res[ResIdxBits-1:0]] = f.tok;
        n_res = n_res + ResCntBits'(1);
      end
      if (f.rescan == RS_DROP_E) begin
        f = feed(s, CLS_EXP, 1'b0, hd_i.pos);
        s = f.st;
        f = feed(s, CLS_OTHER, 1'b1, pt);
        s = f.st;
        if (f.emit) begin
          res[n_res[ResIdxBits-1:0]] = f.tok;
          n_res = n_res + ResCntBits'(1);
        end
      end
      s.mode = MODE_IDLE;
      s.ns   = NsS;
    end
    st_next = s;
  end

  // Head-character tokens go out one per cycle unless pop stalls; the character
  // leaves the queue with its last token, or at once if it has none.
  assign load_ok = !out_valid_q || pop;

  always_comb begin
    commit      = 1'b0;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    if (hd_valid_i) begin
      if (n_res == '0) begin
        commit = 1'b1;
      end else if (load_ok) begin
        out_d            = res[idx_q];
        out_d.end_of_run = ({1'b0, idx_q} == n_res - ResCntBits'(1));
        out_valid_d      = 1'b1;
        if (out_d.end_of_run) begin
          commit = 1'b1;
          idx_d  = '0;
        end else begin
          idx_d = idx_q + ResIdxBits'(1);
        end
      end
    end
  end

  assign hd_pop_o = commit;
  assign empty    = !out_valid_q;
  assign token_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '{mode: MODE_IDLE, ns: NsS, start: '0, len: '0};
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        st_q <= st_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/ident_number_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ident_number_lexer: streaming lexer for identifiers and numbers
// Usage:
//   Characters are written like a queue: item_i holds ch and last, and a
//   transfer happens on a clock edge with push high and full low. Tokens are
//   read like a queue: while empty is low, token_o shows the oldest token,
//   and a transfer happens on an edge with pop high.
//   A character with last set closes any open token and restarts the stream
//   position at zero for the next character.
//   A token closed by a character passes through the two-entry queue and
//   the output register before it is visible on token_o.
//   Throughput: one character per cycle while each character closes at most
//   one token and pop keeps up. A character that closes more tokens (at most
//   three, terminator included) stays at the head of the queue until the last
//   is loaded, since the single output register takes one token per cycle.
//   When pop stays low the output register holds, the two-entry queue
//   behind the classifier fills, and full rises.
//   Reset empties both queues and returns the scanner to idle at position 0.
// ---------------------------------------------------------------------------
module ident_number_lexer import inl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  output logic         full,
  input  wire inl_in_t item_i,
  output logic         empty,
  input  wire logic    pop,
  output inl_out_t     token_o
);

  logic     q_full, q_wr, q_valid, q_rd;
  inl_mid_t q_wdata, q_rdata;

  inl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_data_o (q_wdata)
  );

  inl_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_rdata)
  );

  inl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hd_valid_i (q_valid),
    .hd_i       (q_rdata),
    .hd_pop_o   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .token_o    (token_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/inl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inl_checker: port-level checks for the lexer
// Watches the token side of the top level over time.
// ---------------------------------------------------------------------------
module inl_checker import inl_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     empty,
  input wire logic     pop,
  input wire inl_out_t token_o
);

  // Nothing is offered while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("token offered during reset");

  // A token that is not taken stays on the ports unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(token_o)))
    else $error("waiting token changed or vanished");

  // Error tokens always cover exactly one character.
  a_error_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (token_o.kind == KIND_ERROR)) |-> (token_o.length == LenBits'(1)))
    else $error("error token with length other than one");

  // Every token is at least one character long and of a known kind.
  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((token_o.length != '0) && (token_o.kind != 2'd3)))
    else $error("token with zero length or unknown kind");

endmodule

bind ident_number_lexer inl_checker u_inl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .token_o (token_o)
);
`default_nettype wire

FILE: test/ident_number_lexer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ident_number_lexer_tb: self-checking bench for the identifier/number lexer
// Characters go in through the push/full queue and tokens are drained through
// the pop/empty queue, both with random idle bursts. A cycle-free software
// lexer predicts the tokens of every accepted character, and a checker
// compares each token transfer, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module ident_number_lexer_tb;
  import inl_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // What one scanning step asks for next.
  localparam int FEED_DONE   = 0;
  localparam int FEED_AGAIN  = 1;
  localparam int FEED_DROP_E = 2;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  inl_in_t  item_i;
  logic     empty;
  logic     pop;
  inl_out_t token_o;

  // Lexer shadow state.
  inl_mode_e          lex_mode;
  logic [2:0]         lex_num_st;
  logic [PosBits-1:0] lex_tok_start;
  logic [PosBits-1:0] lex_pos;
  logic [LenBits-1:0] lex_tok_len;
  inl_out_t           step_toks[$];
  inl_out_t           tokens_due[$];

  int  fail_count;
  int  chars_sent;
  int  tokens_checked;
  int  pop_hold;
  int  quiet_cycles;
  bit  calm;

  ident_number_lexer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (item_i),
    .empty  (empty),
    .pop    (pop),
    .token_o(token_o)
  );

  always #2 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Token prediction
  // ------------------------------------------------------------------------
  function automatic logic [2:0] num_next(logic [2:0] st, inl_class_e col);
    logic [2:0] nx;
    nx = NsT;
    case (st)
      NsS: nx = (col == CLS_DIGIT) ? NsA : (col == CLS_DOT) ? NsC : NsT;
      NsA: nx = (col == CLS_DIGIT) ? NsA : (col == CLS_EXP) ? NsE : NsB;
      NsB: nx = (col == CLS_DIGIT) ? NsB : (col == CLS_EXP) ? NsE : NsT;
      NsC: nx = (col == CLS_DIGIT) ? NsD : NsT;
      NsD: nx = (col == CLS_DIGIT) ? NsD : (col == CLS_EXP) ? NsE : NsT;
      NsE, NsF: nx = (col == CLS_DIGIT) ? NsF : NsT;
      default: nx = NsT;
    endcase
    return nx;
  endfunction

  function automatic void lex_emit(inl_kind_e k, logic [PosBits-1:0] start,
                                   logic [LenBits-1:0] len);
    inl_out_t tok;
    tok.kind       = k;
    tok.start_pos  = OutPosBits'(start);
    tok.length     = len;
    tok.end_of_run = 1'b0;
    if (step_toks.size() < NumRes) step_toks.push_back(tok);
  endfunction

  function automatic void lex_close();
    lex_mode   = MODE_IDLE;
    lex_num_st = NsS;
  endfunction

  function automatic void lex_grow();
    if (lex_tok_len != LenMax) lex_tok_len = lex_tok_len + 1'b1;
  endfunction

  function automatic int lex_feed(logic [7:0] c, bit term, logic [PosBits-1:0] at);
    bit         letter;
    bit         digit;
    bit         numch;
    inl_class_e col;
    logic [2:0] nx;
    int         act;
    letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    digit  = (c >= "0" && c <= "9");
    numch  = digit || c == "." || c == "e" || c == "E";
    act    = FEED_DONE;
    case (lex_mode)
      MODE_IDLE: begin
        if (!term) begin
          if (letter) begin
            lex_mode      = MODE_IDENT;
            lex_tok_start = at;
            lex_tok_len   = 1;
          end else if (digit || c == ".") begin
            lex_mode      = MODE_NUM;
            lex_tok_start = at;
            lex_tok_len   = 1;
            lex_num_st    = num_next(NsS, digit ? CLS_DIGIT : CLS_DOT);
          end else if (c != "_") begin
            lex_emit(KIND_ERROR, at, 1);
          end
        end
      end
      MODE_IDENT: begin
        if (!term && (letter || digit)) begin
          lex_grow();
        end else begin
          lex_emit(KIND_IDENT, lex_tok_start, lex_tok_len);
          lex_close();
          act = FEED_AGAIN;
        end
      end
      default: begin
        if (!term && numch) begin
          col = digit ? CLS_DIGIT : (c == ".") ? CLS_DOT : CLS_EXP;
          nx  = num_next(lex_num_st, col);
          if (nx != NsT) begin
            lex_num_st = nx;
            lex_grow();
          end else begin
            // The table gave up: everything so far is kept, the character
            // that stopped it is scanned afresh.
            lex_emit(KIND_NUMBER, lex_tok_start, lex_tok_len);
            lex_close();
            act = FEED_AGAIN;
          end
        end else if (lex_num_st == NsE) begin
          // A trailing exponent letter is given back, unless the length has
          // already saturated.
          lex_emit(KIND_NUMBER, lex_tok_start,
                   (lex_tok_len != LenMax) ? lex_tok_len - 1'b1 : LenMax);
          lex_close();
          act = FEED_DROP_E;
        end else begin
          lex_emit(KIND_NUMBER, lex_tok_start, lex_tok_len);
          lex_close();
          act = FEED_AGAIN;
        end
      end
    endcase
    return act;
  endfunction

  task automatic lex_run(logic [7:0] c, bit term, logic [PosBits-1:0] at);
    int act;
    act = lex_feed(c, term, at);
    if (act == FEED_DROP_E) begin
      void'(lex_feed("e", 1'b0, at - 1'b1));
      act = FEED_AGAIN;
    end
    while (act == FEED_AGAIN) act = lex_feed(c, term, at);
  endtask

  // Works out every token that one accepted character produces.
  task automatic lex_char(logic [7:0] ch, logic last);
    logic [PosBits-1:0] p;
    inl_out_t           tok;
    p = lex_pos;
    step_toks.delete();
    lex_run(ch, 1'b0, p);
    if (last) begin
      lex_run(8'h00, 1'b1, p + 1'b1);
      lex_pos = '0;
    end else begin
      lex_pos = p + 1'b1;
    end
    if (step_toks.size() > 0) begin
      tok = step_toks.pop_back();
      tok.end_of_run = 1'b1;
      step_toks.push_back(tok);
    end
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  // ------------------------------------------------------------------------
  // Character source
  // ------------------------------------------------------------------------
  task automatic send_char(logic [7:0] ch, logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= '{ch: ch, last: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    chars_sent++;
    lex_char(ch, last);
  endtask

  task automatic send_text(string s, bit end_stream);
    for (int i = 0; i < s.len(); i++) send_char(s[i], end_stream && i == s.len() - 1);
  endtask

  task automatic send_word(logic [7:0] word[$], bit end_stream);
    foreach (word[i]) send_char(word[i], end_stream && i == word.size() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_numch();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0, 1, 2: c = rand_digit();
      3:       c = ".";
      4:       c = "e";
      default: c = "E";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_sep();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = " ";
      1:       c = "+";
      2:       c = "_";
      3:       c = "-";
      4:       c = ",";
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Mostly well-formed identifiers and numbers with random content, the rest
  // broken numbers, stray bytes and underscores.
  task automatic gen_random(int n);
    int         first;
    logic [7:0] word[$];
    first = chars_sent;
    while (chars_sent - first < n) begin
      word.delete();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          word.push_back(rand_letter());
          repeat ($urandom_range(0, 7)) word.push_back(rand_alnum());
        end
        4, 5, 6: begin
          if ($urandom_range(0, 4) == 0) begin
            word.push_back(".");
            repeat ($urandom_range(1, 3)) word.push_back(rand_digit());
          end else begin
            repeat ($urandom_range(1, 4)) word.push_back(rand_digit());
            if ($urandom_range(0, 1)) begin
              word.push_back(".");
              repeat ($urandom_range(0, 3)) word.push_back(rand_digit());
            end
          end
          if ($urandom_range(0, 2) == 0) begin
            word.push_back($urandom_range(0, 1) ? "e" : "E");
            if ($urandom_range(0, 3) != 0)
              repeat ($urandom_range(1, 3)) word.push_back(rand_digit());
          end
        end
        7:       repeat ($urandom_range(1, 6)) word.push_back(rand_numch());
        8:       word.push_back(8'($urandom_range(0, 255)));
        default: word.push_back("_");
      endcase
      if ($urandom_range(0, 1)) word.push_back(rand_sep());
      send_word(word, $urandom_range(0, 7) == 0);
    end
  endtask

  // ------------------------------------------------------------------------
  // Token sink and checker
  // ------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_token(inl_out_t got);
    inl_out_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token kind %0d start %0d length %0d with none expected",
                                got.kind, got.start_pos, got.length));
    end else begin
      want = tokens_due.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                  tokens_checked, got.kind, want.kind));
      if (got.start_pos != want.start_pos)
        report_mismatch($sformatf("token %0d start_pos %0d, expected %0d",
                                  tokens_checked, got.start_pos, want.start_pos));
      if (got.length != want.length)
        report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                  tokens_checked, got.length, want.length));
      if (got.end_of_run != want.end_of_run)
        report_mismatch($sformatf("token %0d end_of_run %0d, expected %0d",
                                  tokens_checked, got.end_of_run, want.end_of_run));
    end
    tokens_checked++;
  endtask

  // Checks each token transfer and drives pop, with random stall bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) check_token(token_o);
      if (pop_hold != 0) begin
        pop_hold <= pop_hold - 1;
        pop      <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop_hold <= $urandom_range(0, 6);
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timed out: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    calm = 1'b0;
    send_text("Ab9_", 1'b0);     // identifier closed by an underscore
    send_text("1.5E3+", 1'b0);   // full number, then an error byte
    send_text("12e ", 1'b0);     // trailing exponent letter given back
    send_text("1e.", 1'b0);      // table stops on a dot after the exponent
    send_char(8'h00, 1'b0);      // zero byte is an error
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);
    send_text("7e$", 1'b1);      // dropped e, error and terminator at once
    send_text(".e", 1'b1);       // table stops on an exponent after a dot
  endtask

  task automatic test_random_lexemes();
    calm = 1'b0;
    gen_random(250);
    send_char("_", 1'b1);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    gen_random(40);
    send_text("z", 1'b1);
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    item_i       = '0;
    fail_count   = 0;
    chars_sent   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    lex_mode     = MODE_IDLE;
    lex_num_st   = NsS;
    lex_tok_start = '0;
    lex_pos      = '0;
    lex_tok_len  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_lexemes();
    test_steady_stream();

    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d characters and checked %0d tokens, covering every token kind,",
             chars_sent, tokens_checked);
    $display("dropped exponents, table stops, stream ends and stalls on both sides.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
